// ===== src/cpu8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types and constants for the 8-bit register and ALU execute block.
// ----------------------------------------------------------------------------
package cpu8_pkg;

  typedef enum logic [5:0] {
    OP_ORA  = 6'd0,  OP_AND  = 6'd1,  OP_EOR  = 6'd2,  OP_ADC  = 6'd3,
    OP_SBC  = 6'd4,  OP_CMP  = 6'd5,  OP_CPX  = 6'd6,  OP_CPY  = 6'd7,
    OP_BIT  = 6'd8,  OP_LDA  = 6'd9,  OP_LDX  = 6'd10, OP_LDY  = 6'd11,
    OP_STA  = 6'd12, OP_STX  = 6'd13, OP_STY  = 6'd14, OP_INC  = 6'd15,
    OP_DEC  = 6'd16, OP_INX  = 6'd17, OP_INY  = 6'd18, OP_DEX  = 6'd19,
    OP_DEY  = 6'd20, OP_TAX  = 6'd21, OP_TAY  = 6'd22, OP_TXA  = 6'd23,
    OP_TYA  = 6'd24, OP_TSX  = 6'd25, OP_TXS  = 6'd26, OP_ASLA = 6'd27,
    OP_ASLM = 6'd28, OP_LSRA = 6'd29, OP_LSRM = 6'd30, OP_ROLA = 6'd31,
    OP_ROLM = 6'd32, OP_RORA = 6'd33, OP_RORM = 6'd34, OP_CLC  = 6'd35,
    OP_SEC  = 6'd36, OP_CLI  = 6'd37, OP_SEI  = 6'd38, OP_CLD  = 6'd39,
    OP_SED  = 6'd40, OP_CLV  = 6'd41, OP_PHA  = 6'd42, OP_PHP  = 6'd43,
    OP_PLA  = 6'd44, OP_PLP  = 6'd45, OP_NOP  = 6'd46
  } op_t;

  typedef enum logic [1:0] {
    STK_NONE = 2'd0,
    STK_PUSH = 2'd1,
    STK_PULL = 2'd2
  } stack_acc_t;

  // flag register bit positions: N V D I Z C
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 4;
  localparam int FL_N = 5;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [5:0] FLAGS_RESET = 6'b000100;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [5:0] flags;
  } cpu_state_t;

  typedef struct packed {
    logic       mem_write;
    logic [7:0] write_data;
    stack_acc_t stack_access;
    logic [7:0] stack_slot;
  } side_t;

  // N V 1 1 D I Z C
  function automatic logic [7:0] pack_flags(input logic [5:0] f);
    return {f[FL_N], f[FL_V], 2'b11, f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
  endfunction

endpackage
`default_nettype wire

// ===== src/cpu8_register_alu_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_register_alu_execute
// Accumulator, index, stack and flag execute unit for an 8-bit CPU.
// ----------------------------------------------------------------------------
// Takes decoded operations and returns one result word per operation: the
// word is captured in an input register, executed in one pass against A,
// X, Y, SP and the flags, and the new register values plus any memory or
// stack write land in the result register. Throughput is one word per
// clock while the output is taken; the result register and input register
// let the input keep flowing for one word while the output stalls. Reset
// leaves SP at 0xFD and I set.
module cpu8_register_alu_execute (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // op[5:0], operand_byte[13:6], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // acc_value, x_value, y_value, sp_value, flag_byte, write_data, stack_slot
  output logic [55:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser    // mem_write[0], stack_access[2:1]
);
  import cpu8_pkg::*;

  logic       in_valid;
  logic [5:0] in_op;
  logic [7:0] in_operand;
  logic       advance;
  logic       exec;

  cpu_state_t state;
  cpu_state_t state_next;
  side_t      side_next;

  cpu_state_t out_state;
  side_t      out_side;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign exec          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op      <= s_axis_tdata[5:0];
      in_operand <= s_axis_tdata[13:6];
    end
  end

  cpu8_alu u_alu (
    .op           (in_op),
    .operand_byte (in_operand),
    .cur          (state),
    .nxt          (state_next),
    .side         (side_next)
  );

  cpu8_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .load       (exec),
    .state_next (state_next),
    .state      (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_state <= state_next;
      out_side  <= side_next;
    end
  end

  assign m_axis_tdata = {out_side.stack_slot, out_side.write_data,
                         pack_flags(out_state.flags), out_state.sp,
                         out_state.y, out_state.x, out_state.acc};
  assign m_axis_tuser = {out_side.stack_access, out_side.mem_write};

  // SP moves only for stack operations and TXS
  a_sp_hold: assert property (@(posedge clk) disable iff (rst)
    (exec && !(in_op == OP_PHA || in_op == OP_PHP || in_op == OP_PLA ||
               in_op == OP_PLP || in_op == OP_TXS)) |=> $stable(state.sp))
    else $error("stack pointer moved on a non-stack operation");

  a_wdata_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_side.mem_write) |-> (out_side.write_data == 8'd0))
    else $error("write data not zero without a write");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_side.stack_access == STK_NONE) |-> (out_side.stack_slot == 8'd0))
    else $error("stack slot not zero without stack access");

  a_push_writes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_side.stack_access == STK_PUSH) |->
      (out_side.mem_write && out_state.sp == out_side.stack_slot - 8'd1))
    else $error("push without write or wrong stack pointer");

endmodule
`default_nettype wire

// ===== src/cpu8_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_alu
// Single-pass execute logic: next register state and memory side effects.
// ----------------------------------------------------------------------------
module cpu8_alu (
  input  wire logic [5:0]          op,
  input  wire logic [7:0]          operand_byte,
  input  wire cpu8_pkg::cpu_state_t cur,
  output cpu8_pkg::cpu_state_t     nxt,
  output cpu8_pkg::side_t          side
);
  import cpu8_pkg::*;

  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // returns {carry out, result}
  function automatic logic [8:0] shift_byte(input logic [7:0] v, input shift_kind_t k,
                                            input logic cin);
    logic [8:0] r;
    case (k)
      SH_ASL:  r = {v[7], v[6:0], 1'b0};
      SH_ROL:  r = {v[7], v[6:0], cin};
      SH_LSR:  r = {v[0], 1'b0, v[7:1]};
      default: r = {v[0], cin, v[7:1]};
    endcase
    return r;
  endfunction

  logic [7:0] m;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_reg;
  logic [7:0] zn_val;
  logic       zn_en;
  logic [8:0] sh;

  assign m = operand_byte;

  always_comb begin
    nxt     = cur;
    side    = '0;
    zn_val  = '0;
    zn_en   = 1'b0;
    sh      = '0;
    sum     = {1'b0, cur.acc} + {1'b0, (op == OP_SBC) ? ~m : m} + {8'd0, cur.flags[FL_C]};
    cmp_reg = (op == OP_CPX) ? cur.x : (op == OP_CPY) ? cur.y : cur.acc;
    diff    = {1'b0, cmp_reg} - {1'b0, m};

    unique case (op) inside
      OP_ORA: begin nxt.acc = cur.acc | m; zn_val = nxt.acc; zn_en = 1'b1; end
      OP_AND: begin nxt.acc = cur.acc & m; zn_val = nxt.acc; zn_en = 1'b1; end
      OP_EOR: begin nxt.acc = cur.acc ^ m; zn_val = nxt.acc; zn_en = 1'b1; end
      OP_ADC, OP_SBC: begin
        nxt.acc         = sum[7:0];
        nxt.flags[FL_C] = sum[8];
        nxt.flags[FL_V] = (cur.acc[7] ^ sum[7]) & (((op == OP_SBC) ? ~m[7] : m[7]) ^ sum[7]);
        zn_val = sum[7:0];
        zn_en  = 1'b1;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.flags[FL_C] = ~diff[8];
        zn_val = diff[7:0];
        zn_en  = 1'b1;
      end
      OP_BIT: begin
        nxt.flags[FL_Z] = (cur.acc & m) == 8'd0;
        nxt.flags[FL_V] = m[6];
        nxt.flags[FL_N] = m[7];
      end
      OP_LDA: begin nxt.acc = m; zn_val = m; zn_en = 1'b1; end
      OP_LDX: begin nxt.x = m; zn_val = m; zn_en = 1'b1; end
      OP_LDY: begin nxt.y = m; zn_val = m; zn_en = 1'b1; end
      OP_STA: begin side.mem_write = 1'b1; side.write_data = cur.acc; end
      OP_STX: begin side.mem_write = 1'b1; side.write_data = cur.x; end
      OP_STY: begin side.mem_write = 1'b1; side.write_data = cur.y; end
      OP_INC: begin
        side.mem_write = 1'b1; side.write_data = m + 8'd1;
        zn_val = side.write_data; zn_en = 1'b1;
      end
      OP_DEC: begin
        side.mem_write = 1'b1; side.write_data = m - 8'd1;
        zn_val = side.write_data; zn_en = 1'b1;
      end
      OP_INX: begin nxt.x = cur.x + 8'd1; zn_val = nxt.x; zn_en = 1'b1; end
      OP_INY: begin nxt.y = cur.y + 8'd1; zn_val = nxt.y; zn_en = 1'b1; end
      OP_DEX: begin nxt.x = cur.x - 8'd1; zn_val = nxt.x; zn_en = 1'b1; end
      OP_DEY: begin nxt.y = cur.y - 8'd1; zn_val = nxt.y; zn_en = 1'b1; end
      OP_TAX: begin nxt.x = cur.acc; zn_val = cur.acc; zn_en = 1'b1; end
      OP_TAY: begin nxt.y = cur.acc; zn_val = cur.acc; zn_en = 1'b1; end
      OP_TXA: begin nxt.acc = cur.x; zn_val = cur.x; zn_en = 1'b1; end
      OP_TYA: begin nxt.acc = cur.y; zn_val = cur.y; zn_en = 1'b1; end
      OP_TSX: begin nxt.x = cur.sp; zn_val = cur.sp; zn_en = 1'b1; end
      OP_TXS: nxt.sp = cur.x;
      OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA: begin
        sh = shift_byte(cur.acc, shift_kind_t'(op[2:1] - 2'd1), cur.flags[FL_C]);
        nxt.acc         = sh[7:0];
        nxt.flags[FL_C] = sh[8];
        zn_val = sh[7:0];
        zn_en  = 1'b1;
      end
      OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM: begin
        sh = shift_byte(m, shift_kind_t'(op[2:1] - 2'd2), cur.flags[FL_C]);
        side.mem_write  = 1'b1;
        side.write_data = sh[7:0];
        nxt.flags[FL_C] = sh[8];
        zn_val = sh[7:0];
        zn_en  = 1'b1;
      end
      OP_CLC: nxt.flags[FL_C] = 1'b0;
      OP_SEC: nxt.flags[FL_C] = 1'b1;
      OP_CLI: nxt.flags[FL_I] = 1'b0;
      OP_SEI: nxt.flags[FL_I] = 1'b1;
      OP_CLD: nxt.flags[FL_D] = 1'b0;
      OP_SED: nxt.flags[FL_D] = 1'b1;
      OP_CLV: nxt.flags[FL_V] = 1'b0;
      OP_PHA, OP_PHP: begin
        side.mem_write    = 1'b1;
        side.stack_access = STK_PUSH;
        side.stack_slot   = cur.sp;
        side.write_data   = (op == OP_PHA) ? cur.acc : pack_flags(cur.flags);
        nxt.sp            = cur.sp - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        side.stack_access = STK_PULL;
        nxt.sp            = cur.sp + 8'd1;
        side.stack_slot   = nxt.sp;
        if (op == OP_PLA) begin
          nxt.acc = m;
          zn_val  = m;
          zn_en   = 1'b1;
        end else begin
          nxt.flags = {m[7], m[6], m[3], m[2], m[1], m[0]};
        end
      end
      default: ;
    endcase

    if (zn_en) begin
      nxt.flags[FL_Z] = zn_val == 8'd0;
      nxt.flags[FL_N] = zn_val[7];
    end
  end

endmodule
`default_nettype wire

// ===== src/cpu8_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_regs
// Architectural registers A, X, Y, SP and flags, loaded once per word.
// ----------------------------------------------------------------------------
module cpu8_regs (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire cpu8_pkg::cpu_state_t state_next,
  output cpu8_pkg::cpu_state_t      state
);
  import cpu8_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.acc   <= 8'd0;
      state.x     <= 8'd0;
      state.y     <= 8'd0;
      state.sp    <= SP_RESET;
      state.flags <= FLAGS_RESET;
    end else if (load) begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8-bit register and ALU execute unit.
// ----------------------------------------------------------------------------
// Operation words go in on the input stream, either from a directed list that
// hits every operation and the flag and stack corner cases, or at random. A
// shadow copy of A, X, Y, SP and the flags is stepped on each accepted word,
// and every result word is checked field by field against the oldest
// prediction. Both stream sides idle at random. The result side holds off
// once for a long stretch, and the input side waits twice for the pipeline
// to drain.
// ----------------------------------------------------------------------------
module testbench;
  import cpu8_pkg::*;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] flag_byte;
    logic       mem_write;
    logic [7:0] write_data;
    stack_acc_t stack_access;
    logic [7:0] stack_slot;
  } outcome_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
    bit         drain_first;
  } op_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  op_word_t pending_q[$];
  outcome_t expected_q[$];
  int       sent_cnt = 0;
  int       seen_cnt = 0;
  int       err_cnt = 0;
  int       hold_cycles = 0;
  int       hold_seen = 0;
  bit       hold_done = 1'b0;

  // shadow machine state
  logic [7:0] a_sh = 8'h00;
  logic [7:0] x_sh = 8'h00;
  logic [7:0] y_sh = 8'h00;
  logic [7:0] sp_sh = SP_RESET;
  logic [5:0] fl_sh = FLAGS_RESET;

  cpu8_register_alu_execute dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] flag_image();
    return {fl_sh[FL_N], fl_sh[FL_V], 2'b11, fl_sh[FL_D], fl_sh[FL_I], fl_sh[FL_Z],
            fl_sh[FL_C]};
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] v);
    fl_sh[FL_Z] = (v == 8'h00);
    fl_sh[FL_N] = v[7];
    return v;
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    fl_sh[FL_C] = (r >= m);
    void'(set_nz(diff));
  endfunction

  function automatic logic [7:0] add_with_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, a_sh} + {1'b0, m} + {8'h00, fl_sh[FL_C]};
    fl_sh[FL_C] = sum[8];
    fl_sh[FL_V] = (a_sh[7] ^ sum[7]) & (m[7] ^ sum[7]);
    return set_nz(sum[7:0]);
  endfunction

  function automatic logic [7:0] shift_val(input logic [7:0] v, input bit left,
                                           input bit rotate);
    logic       cin;
    logic [7:0] r;
    cin = fl_sh[FL_C];
    if (left) begin
      fl_sh[FL_C] = v[7];
      r = {v[6:0], rotate & cin};
    end else begin
      fl_sh[FL_C] = v[0];
      r = {rotate & cin, v[7:1]};
    end
    return set_nz(r);
  endfunction

  function automatic outcome_t execute_op(input op_t op, input logic [7:0] m);
    outcome_t r;
    r = '0;
    r.stack_access = STK_NONE;
    case (op)
      OP_ORA:  a_sh = set_nz(a_sh | m);
      OP_AND:  a_sh = set_nz(a_sh & m);
      OP_EOR:  a_sh = set_nz(a_sh ^ m);
      OP_ADC:  a_sh = add_with_carry(m);
      OP_SBC:  a_sh = add_with_carry(~m);
      OP_CMP:  compare_reg(a_sh, m);
      OP_CPX:  compare_reg(x_sh, m);
      OP_CPY:  compare_reg(y_sh, m);
      OP_BIT: begin
        fl_sh[FL_Z] = ((a_sh & m) == 8'h00);
        fl_sh[FL_V] = m[6];
        fl_sh[FL_N] = m[7];
      end
      OP_LDA:  a_sh = set_nz(m);
      OP_LDX:  x_sh = set_nz(m);
      OP_LDY:  y_sh = set_nz(m);
      OP_STA: begin
        r.mem_write = 1'b1;
        r.write_data = a_sh;
      end
      OP_STX: begin
        r.mem_write = 1'b1;
        r.write_data = x_sh;
      end
      OP_STY: begin
        r.mem_write = 1'b1;
        r.write_data = y_sh;
      end
      OP_INC: begin
        r.mem_write = 1'b1;
        r.write_data = set_nz(m + 8'd1);
      end
      OP_DEC: begin
        r.mem_write = 1'b1;
        r.write_data = set_nz(m - 8'd1);
      end
      OP_INX:  x_sh = set_nz(x_sh + 8'd1);
      OP_INY:  y_sh = set_nz(y_sh + 8'd1);
      OP_DEX:  x_sh = set_nz(x_sh - 8'd1);
      OP_DEY:  y_sh = set_nz(y_sh - 8'd1);
      OP_TAX:  x_sh = set_nz(a_sh);
      OP_TAY:  y_sh = set_nz(a_sh);
      OP_TXA:  a_sh = set_nz(x_sh);
      OP_TYA:  a_sh = set_nz(y_sh);
      OP_TSX:  x_sh = set_nz(sp_sh);
      OP_TXS:  sp_sh = x_sh;
      OP_ASLA: a_sh = shift_val(a_sh, 1'b1, 1'b0);
      OP_LSRA: a_sh = shift_val(a_sh, 1'b0, 1'b0);
      OP_ROLA: a_sh = shift_val(a_sh, 1'b1, 1'b1);
      OP_RORA: a_sh = shift_val(a_sh, 1'b0, 1'b1);
      OP_ASLM: begin
        r.mem_write = 1'b1;
        r.write_data = shift_val(m, 1'b1, 1'b0);
      end
      OP_LSRM: begin
        r.mem_write = 1'b1;
        r.write_data = shift_val(m, 1'b0, 1'b0);
      end
      OP_ROLM: begin
        r.mem_write = 1'b1;
        r.write_data = shift_val(m, 1'b1, 1'b1);
      end
      OP_RORM: begin
        r.mem_write = 1'b1;
        r.write_data = shift_val(m, 1'b0, 1'b1);
      end
      OP_CLC:  fl_sh[FL_C] = 1'b0;
      OP_SEC:  fl_sh[FL_C] = 1'b1;
      OP_CLI:  fl_sh[FL_I] = 1'b0;
      OP_SEI:  fl_sh[FL_I] = 1'b1;
      OP_CLD:  fl_sh[FL_D] = 1'b0;
      OP_SED:  fl_sh[FL_D] = 1'b1;
      OP_CLV:  fl_sh[FL_V] = 1'b0;
      OP_PHA, OP_PHP: begin
        r.mem_write = 1'b1;
        r.stack_access = STK_PUSH;
        r.stack_slot = sp_sh;
        r.write_data = (op == OP_PHA) ? a_sh : flag_image();
        sp_sh = sp_sh - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        r.stack_access = STK_PULL;
        sp_sh = sp_sh + 8'd1;
        r.stack_slot = sp_sh;
        if (op == OP_PLA) begin
          a_sh = set_nz(m);
        end else begin
          fl_sh[FL_N] = m[7];
          fl_sh[FL_V] = m[6];
          fl_sh[FL_D] = m[3];
          fl_sh[FL_I] = m[2];
          fl_sh[FL_Z] = m[1];
          fl_sh[FL_C] = m[0];
        end
      end
      default: ;
    endcase
    r.acc = a_sh;
    r.x = x_sh;
    r.y = y_sh;
    r.sp = sp_sh;
    r.flag_byte = flag_image();
    return r;
  endfunction

  function automatic void add_word(input op_t op, input logic [7:0] operand,
                                   input bit drain_first = 1'b0);
    op_word_t w;
    w.op = op;
    w.operand = operand;
    w.drain_first = drain_first;
    pending_q.push_back(w);
  endfunction

  // input side: predicts on acceptance, then offers the next word
  always @(posedge clk) begin : drive_blk
    op_word_t w;
    bit       offer;
    bit       calm;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(execute_op(op_t'(s_axis_tdata[5:0]), s_axis_tdata[13:6]));
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        calm = (sent_cnt >= 450) && (sent_cnt < 650);
        offer = (pending_q.size() > 0) && (calm || ($urandom_range(99) >= 34));
        if (offer && pending_q[0].drain_first && expected_q.size() != 0)
          offer = 1'b0;
        if (offer) begin
          w = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, w.operand, w.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side, counted in cycles
  always @(posedge clk) begin : hold_blk
    if (rst) begin
      hold_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        hold_seen++;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && hold_seen == 400) begin
        hold_done <= 1'b1;
        hold_cycles <= 300;
      end
    end
  end

  // result side: checks each accepted word and drives tready
  always @(posedge clk) begin : check_blk
    outcome_t got;
    outcome_t want;
    bit       calm;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.acc = m_axis_tdata[7:0];
        got.x = m_axis_tdata[15:8];
        got.y = m_axis_tdata[23:16];
        got.sp = m_axis_tdata[31:24];
        got.flag_byte = m_axis_tdata[39:32];
        got.write_data = m_axis_tdata[47:40];
        got.stack_slot = m_axis_tdata[55:48];
        got.mem_write = m_axis_tuser[0];
        got.stack_access = stack_acc_t'(m_axis_tuser[2:1]);
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: result word %0d with nothing predicted: tdata %h tuser %b",
                     seen_cnt, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_q.pop_front();
          if (got.acc !== want.acc || got.x !== want.x || got.y !== want.y ||
              got.sp !== want.sp || got.flag_byte !== want.flag_byte ||
              got.mem_write !== want.mem_write || got.write_data !== want.write_data ||
              got.stack_access !== want.stack_access ||
              got.stack_slot !== want.stack_slot) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("ERROR: result word %0d mismatch (expected / actual)", seen_cnt);
              $display("  a %h/%h x %h/%h y %h/%h sp %h/%h p %h/%h",
                       want.acc, got.acc, want.x, got.x, want.y, got.y,
                       want.sp, got.sp, want.flag_byte, got.flag_byte);
              $display("  wr %b/%b data %h/%h stack %0d/%0d slot %h/%h",
                       want.mem_write, got.mem_write, want.write_data, got.write_data,
                       want.stack_access, got.stack_access, want.stack_slot,
                       got.stack_slot);
            end
          end
        end
        seen_cnt++;
      end
      calm = (seen_cnt >= 450) && (seen_cnt < 650);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin : stim_blk
    logic [7:0] operand;
    int         i;
    int         guard;

    // directed: every operation, flag corners, stack wrap both ways
    add_word(OP_LDA, 8'h00);
    add_word(OP_LDA, 8'h7F);
    add_word(OP_ADC, 8'h01);   // signed overflow into negative
    add_word(OP_ADC, 8'hFF);   // carry out and overflow
    add_word(OP_SBC, 8'h00);
    add_word(OP_CMP, 8'h7F);   // equal
    add_word(OP_CMP, 8'hFF);   // register below operand
    add_word(OP_CPX, 8'h00);
    add_word(OP_CPY, 8'hFF);
    add_word(OP_BIT, 8'hC0);
    add_word(OP_BIT, 8'h00);
    add_word(OP_EOR, 8'hFF);
    add_word(OP_ORA, 8'h00);
    add_word(OP_AND, 8'h00);
    add_word(OP_LDX, 8'hFF);
    add_word(OP_LDY, 8'h80);
    add_word(OP_STA, 8'h00);
    add_word(OP_STX, 8'hFF);
    add_word(OP_STY, 8'h55);
    add_word(OP_INC, 8'hFF);   // wraps to zero
    add_word(OP_DEC, 8'h00);   // wraps to FF
    add_word(OP_INX, 8'h00);
    add_word(OP_INY, 8'h00);
    add_word(OP_DEX, 8'h00);
    add_word(OP_DEY, 8'h00);
    add_word(OP_TAX, 8'h00);
    add_word(OP_TAY, 8'h00);
    add_word(OP_TXA, 8'h00);
    add_word(OP_TYA, 8'h00);
    add_word(OP_TSX, 8'h00);
    add_word(OP_LDX, 8'h00);
    add_word(OP_TXS, 8'h00);   // SP at 00: next push wraps
    add_word(OP_SED, 8'h00);
    add_word(OP_PHA, 8'h00);
    add_word(OP_PHP, 8'h00);   // bits 5 and 4 forced on the pushed byte
    add_word(OP_PLA, 8'hFF);
    add_word(OP_PLP, 8'hFF);   // bits 5 and 4 dropped, pull wraps SP back to 00
    add_word(OP_PLP, 8'h00);
    add_word(OP_PLA, 8'h81);   // negative byte from the stack
    add_word(OP_SEC, 8'h00);
    add_word(OP_ASLA, 8'h00);
    add_word(OP_ASLM, 8'h80);
    add_word(OP_LSRA, 8'h00);
    add_word(OP_LSRM, 8'h01);
    add_word(OP_ROLA, 8'h00);
    add_word(OP_ROLM, 8'hFF);
    add_word(OP_RORA, 8'h00);
    add_word(OP_RORM, 8'h01);
    add_word(OP_CLC, 8'h00);
    add_word(OP_CLI, 8'h00);
    add_word(OP_SEI, 8'h00);
    add_word(OP_CLD, 8'h00);
    add_word(OP_CLV, 8'h00);
    add_word(OP_NOP, 8'hA5);

    for (i = 0; i < 1050; i++) begin
      case ($urandom_range(9))
        0: operand = 8'h00;
        1: operand = 8'hFF;
        2: operand = 8'h80;
        3: operand = 8'h7F;
        default: operand = 8'($urandom_range(255));
      endcase
      add_word(op_t'($urandom_range(46)), operand, (i == 0) || (i == 700));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk);
    guard = 0;
    while (guard < 10) begin
      @(posedge clk);
      guard++;
    end

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : timeout_blk
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
